[rtl/lbp_pkg.sv]
// Shared constants, types and helper functions for the 3x3 LBP code stream block.
// No dependencies; every other file in this block imports this package.

package lbp_pkg;

    // Line store depth and derived column counter width
    localparam int MAX_WIDTH  = 1024;
    localparam int COL_W      = $clog2(MAX_WIDTH);

    // Field widths
    localparam int PIX_W      = 8;
    localparam int CODE_W     = 8;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int FLIPS_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int MAP_DEPTH  = 1 << CODE_W;

    // Register reset values and dimension limits
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = HEIGHT_W'(480);
    localparam logic [FLIPS_W-1:0]  FLIPS_RST  = FLIPS_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);

    // Number of uniform codes for each transition limit (transition counts are even)
    localparam logic [CODE_W-1:0] UNI_CNT_0 = CODE_W'(2);
    localparam logic [CODE_W-1:0] UNI_CNT_2 = CODE_W'(58);
    localparam logic [CODE_W-1:0] UNI_CNT_4 = CODE_W'(198);
    localparam logic [CODE_W-1:0] UNI_CNT_6 = CODE_W'(254);
    localparam logic [CODE_W-1:0] UNI_CNT_8 = CODE_W'(0);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_MAX_FLIPS    = 2'd2
    } cfg_reg_t;

    // Line store request: read/write at the new pixel's column, copy to the
    // upper store at the column of the item one stage on
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_col;
        logic [PIX_W-1:0] px;
        logic             wb_en;
        logic [COL_W-1:0] wb_col;
    } lb_req_t;

    // Count circular bit transitions of a code
    function automatic logic [3:0] code_transitions(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] diff;
        logic [3:0]        n;
        diff = code ^ {code[0], code[CODE_W-1:1]};
        n = 4'd0;
        for (int i = 0; i < CODE_W; i++)
        begin
            n = n + {3'd0, diff[i]};
        end
        return n;
    endfunction

    // Bin id given to every non-uniform code
    function automatic logic [CODE_W-1:0] uniform_total(input logic [FLIPS_W-1:0] flips);
        logic [CODE_W-1:0] total;
        case (flips)
            4'd0, 4'd1: total = UNI_CNT_0;
            4'd2, 4'd3: total = UNI_CNT_2;
            4'd4, 4'd5: total = UNI_CNT_4;
            4'd6, 4'd7: total = UNI_CNT_6;
            default:    total = UNI_CNT_8;
        endcase
        return total;
    endfunction

endpackage

[rtl/lbp_if.sv]
// Valid/ready stream interfaces for pixels in and pattern codes out.
// Depends on lbp_pkg for field widths.

interface lbp_pix_if import lbp_pkg::*;
    ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface lbp_code_if import lbp_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] pattern;
    logic              frame_last;

    modport source (output valid, output pattern, output frame_last, input ready);
    modport sink   (input valid, input pattern, input frame_last, output ready);
endinterface

[rtl/lbp_3x3_uniform_code_stream_top.sv]
// Top level of the 3x3 local binary pattern code stream block.
// Depends on lbp_pkg, lbp_if, lbp_line_buf and lbp_uni_map.
//
// Takes one 8-bit grey pixel per clock in row-major order and gives one
// 8-bit code per interior pixel; border pixels give no result, and the code
// for a centre pixel is produced once the pixel to its lower right arrives.
// Throughput is one pixel per clock while the output takes results and no
// table build is running. A result passes from the pixel that completes its
// window through the line store read register, the window and the read
// register of the remap table, and an output stall can hold it on the way.
// After reset and after every write of max_flips the remap table is rebuilt
// by a sweep, one entry per cycle, during which no pixel is accepted;
// configuration writes are taken at any time but belong between frames when
// the block is idle. Width is clamped to 3..1024 and height to at least 3.

module lbp_3x3_uniform_code_stream_top import lbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    lbp_pix_if.sink               pix,
    lbp_code_if.source            code
);

    // Configuration registers
    logic [WIDTH_W-1:0]  image_width_reg;
    logic [HEIGHT_W-1:0] image_height_reg;
    logic [FLIPS_W-1:0]  max_flips_reg;
    logic                map_rebuild;

    // Position counters
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [HEIGHT_W-1:0] row_reg;
    logic [HEIGHT_W-1:0] row_next;

    // Stage 1: line store read
    logic                s1_valid_reg;
    logic                s1_emit_reg;
    logic                s1_last_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [PIX_W-1:0]    s1_px_reg;

    // Stage 2: window; stage 3: result register
    logic [PIX_W-1:0]    window_reg [3][3];
    logic                s2_valid_reg;
    logic                s2_last_reg;
    logic                s3_valid_reg;
    logic                s3_last_reg;

    logic                en1;
    logic                en2;
    logic                en3;
    logic                s1_adv;
    logic                s2_adv;
    logic                pix_fire;
    logic                map_busy;
    logic [WIDTH_W-1:0]  w_eff;
    logic [HEIGHT_W-1:0] h_eff;
    logic                col_end;
    logic                row_end;
    logic                emit;
    logic [PIX_W-1:0]    top_px;
    logic [PIX_W-1:0]    mid_px;
    logic [CODE_W-1:0]   code_word;
    logic [PIX_W-1:0]    cx;
    lb_req_t             lb_req;

    // Write configuration registers; a max_flips write starts a table build
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= WIDTH_RST;
            image_height_reg <= HEIGHT_RST;
            max_flips_reg    <= FLIPS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_MAX_FLIPS:    max_flips_reg    <= cfg_data[FLIPS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign map_rebuild = cfg_we && (cfg_reg_t'(cfg_index) == REG_MAX_FLIPS);

    // Clamp frame dimensions
    always_comb
    begin
        if (image_width_reg < WIDTH_MIN)
        begin
            w_eff = WIDTH_MIN;
        end
        else if (image_width_reg > WIDTH_MAX)
        begin
            w_eff = WIDTH_MAX;
        end
        else
        begin
            w_eff = image_width_reg;
        end
        h_eff = (image_height_reg < HEIGHT_MIN) ? HEIGHT_MIN : image_height_reg;
    end

    // Stage enables: a stage loads when it is empty or its successor moves
    assign en3      = !s3_valid_reg || code.ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign s1_adv   = s1_valid_reg && en2;
    assign s2_adv   = s2_valid_reg && en3;
    assign pix.ready = en1 && !map_busy;
    assign pix_fire = pix.valid && pix.ready;

    // Decode position of the incoming pixel
    always_comb
    begin
        col_end = {{(WIDTH_W-COL_W){1'b0}}, col_reg} >= (w_eff - 1'b1);
        row_end = row_reg >= (h_eff - 1'b1);
        emit    = (row_reg >= HEIGHT_W'(2)) && (col_reg >= COL_W'(2));
        col_next = col_reg + 1'b1;
        row_next = row_reg;
        if (col_end)
        begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + 1'b1;
        end
    end

    // Advance position counters on each request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Line stores
    always_comb
    begin
        lb_req.rd_en  = pix_fire;
        lb_req.rd_col = col_reg;
        lb_req.px     = pix.pixel;
        lb_req.wb_en  = s1_adv;
        lb_req.wb_col = s1_col_reg;
    end

    lbp_line_buf u_line_buf
    (
        .clk    (clk),
        .req    (lb_req),
        .top_px (top_px),
        .mid_px (mid_px)
    );

    // Pipeline control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= pix_fire;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (pix_fire)
        begin
            s1_px_reg   <= pix.pixel;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit;
            s1_last_reg <= row_end && col_end;
        end
        if (s1_adv)
        begin
            s2_last_reg <= s1_last_reg;
            for (int r = 0; r < 3; r++)
            begin
                window_reg[r][0] <= window_reg[r][1];
                window_reg[r][1] <= window_reg[r][2];
            end
            window_reg[0][2] <= top_px;
            window_reg[1][2] <= mid_px;
            window_reg[2][2] <= s1_px_reg;
        end
        if (s2_adv)
        begin
            s3_last_reg <= s2_last_reg;
        end
    end

    // Compare neighbors with the center, counter-clockwise from left-middle
    always_comb
    begin
        cx = window_reg[1][1];
        code_word[7] = window_reg[1][0] > cx;
        code_word[6] = window_reg[2][0] > cx;
        code_word[5] = window_reg[2][1] > cx;
        code_word[4] = window_reg[2][2] > cx;
        code_word[3] = window_reg[1][2] > cx;
        code_word[2] = window_reg[0][2] > cx;
        code_word[1] = window_reg[0][1] > cx;
        code_word[0] = window_reg[0][0] > cx;
    end

    // Remap table; its read register is the result payload
    lbp_uni_map u_uni_map
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rebuild   (map_rebuild),
        .max_flips (max_flips_reg),
        .rd_en     (s2_adv),
        .rd_code   (code_word),
        .rd_data   (code.pattern),
        .busy      (map_busy)
    );

    assign code.valid      = s3_valid_reg;
    assign code.frame_last = s3_last_reg;

endmodule

[rtl/lbp_line_buf.sv]
// Two line stores holding the previous two image rows, one read port each.
// Depends on lbp_pkg (lb_req_t, MAX_WIDTH).

module lbp_line_buf import lbp_pkg::*;
(
    input  logic             clk,
    input  lb_req_t          req,
    output logic [PIX_W-1:0] top_px,
    output logic [PIX_W-1:0] mid_px
);

    logic [PIX_W-1:0] store_a [MAX_WIDTH];
    logic [PIX_W-1:0] store_b [MAX_WIDTH];
    logic [PIX_W-1:0] top_px_reg;
    logic [PIX_W-1:0] mid_px_reg;

    // Read the middle row at the new column, then replace that entry with the new pixel
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            mid_px_reg          <= store_a[req.rd_col];
            store_a[req.rd_col] <= req.px;
        end
    end

    // Read the top row; move the old middle entry up one stage later
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            top_px_reg <= store_b[req.rd_col];
        end
        if (req.wb_en)
        begin
            store_b[req.wb_col] <= mid_px_reg;
        end
    end

    assign top_px = top_px_reg;
    assign mid_px = mid_px_reg;

endmodule

[rtl/lbp_uni_map.sv]
// Uniform-pattern remap table with a build sweep and a registered read port.
// Depends on lbp_pkg (code_transitions, uniform_total).

module lbp_uni_map import lbp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               rebuild,
    input  logic [FLIPS_W-1:0] max_flips,
    input  logic               rd_en,
    input  logic [CODE_W-1:0]  rd_code,
    output logic [CODE_W-1:0]  rd_data,
    output logic               busy
);

    logic [CODE_W-1:0] map_mem [MAP_DEPTH];
    logic [CODE_W-1:0] rd_data_reg;
    logic              busy_reg;
    logic              busy_next;
    logic [CODE_W-1:0] idx_reg;
    logic [CODE_W-1:0] idx_next;
    logic [CODE_W-1:0] rank_reg;
    logic [CODE_W-1:0] rank_next;
    logic              is_uniform;
    logic [CODE_W-1:0] wr_val;

    // Classify the entry under the sweep pointer
    always_comb
    begin
        is_uniform = code_transitions(idx_reg) <= max_flips;
        wr_val     = is_uniform ? rank_reg : uniform_total(max_flips);
    end

    // Advance the sweep: rank counts uniform codes in ascending order
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        rank_next = rank_reg;
        if (rebuild)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            rank_next = '0;
        end
        else if (busy_reg)
        begin
            idx_next  = idx_reg + 1'b1;
            rank_next = is_uniform ? rank_reg + 1'b1 : rank_reg;
            if (idx_reg == {CODE_W{1'b1}})
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Hold sweep state; a build starts out of reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
            rank_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            rank_reg <= rank_next;
        end
    end

    // Table memory: sweep writes, pipeline reads
    always_ff @(posedge clk)
    begin
        if (busy_reg && !rebuild)
        begin
            map_mem[idx_reg] <= wr_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_code];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

[rtl/lbp_checker.sv]
// Port-level checks for the LBP code stream top level, attached by bind.
// Depends on lbp_pkg and lbp_3x3_uniform_code_stream_top.

module lbp_checker import lbp_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic                 pix_ready,
    input logic                 code_valid,
    input logic                 code_ready,
    input logic [CODE_W-1:0]    code_pattern,
    input logic                 code_frame_last
);

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        code_valid && !code_ready |=> code_valid && $stable(code_pattern)
            && $stable(code_frame_last))
        else $error("result changed while stalled");

    // Pixel input is held off at the start of the table build that follows a max_flips write
    a_build_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_index == REG_MAX_FLIPS) |=> !pix_ready ##1 !pix_ready)
        else $error("pixel accepted during table build");

    // Leaving reset starts a table build, so input is held off
    a_reset_build: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !pix_ready)
        else $error("pixel ready right after reset");

    // No result is shown while in reset
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !code_valid)
        else $error("result valid during reset");

endmodule

bind lbp_3x3_uniform_code_stream_top lbp_checker u_lbp_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .pix_ready       (pix.ready),
    .code_valid      (code.valid),
    .code_ready      (code.ready),
    .code_pattern    (code.pattern),
    .code_frame_last (code.frame_last)
);
